[src/cpi_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the color palette indexer.
// No dependencies; imported by every module of the block.
package cpi_pkg;

  localparam int PALETTE_SIZE_DEF  = 1024;
  localparam int MAX_DIMENSION_DEF = 4096;

  localparam int COLOR_W      = 24;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;
  localparam int PAL_INDEX_W  = 10;
  localparam int POS_W        = 12;
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 40;

  // output tdata bit positions
  localparam int OUT_NEW_BIT  = 10;
  localparam int OUT_FULL_BIT = 11;
  localparam int OUT_ROW_LSB  = 12;
  localparam int OUT_COL_LSB  = 24;
  localparam int OUT_OK_BIT   = 36;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  typedef struct packed {
    logic load;     // latch accepted pixel, restart scan
    logic scan;     // step the palette scan
    logic resolve;  // settle hit / append / full
    logic emit;     // load output register, advance raster position
  } cpi_cmd_t;

  typedef struct packed {
    logic hit;        // registered palette read matches the pixel color
    logic scan_done;  // every used entry has been read
    logic out_free;   // output register can take a result
  } cpi_sts_t;

endpackage

[src/cpi_ctrl.sv]
`timescale 1ns / 1ps
// Controller FSM for the color palette indexer.
// Depends on cpi_pkg (command and status structs).
module cpi_ctrl
  import cpi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  cpi_sts_t sts,
  output cpi_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit || sts.scan_done) begin
          cmd.resolve = 1'b1;
          state_nxt   = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/cpi_datapath.sv]
`timescale 1ns / 1ps
// Datapath: palette memory with serial search, raster counters, size
// registers and output register. Depends on cpi_pkg.
module cpi_datapath
  import cpi_pkg::*;
#(
  parameter int PALETTE_SIZE  = PALETTE_SIZE_DEF,
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  cpi_cmd_t               cmd,
  output cpi_sts_t               sts,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int IDX_W = $clog2(PALETTE_SIZE);
  localparam int UW    = $clog2(PALETTE_SIZE + 1);
  localparam int DIM_W = $clog2(MAX_DIMENSION);
  localparam int CW    = (DIM_W + 1 > CFG_DATA_W) ? DIM_W + 1 : CFG_DATA_W;

  // palette store, no reset: only entries below used_r are read
  logic [COLOR_W-1:0] mem [PALETTE_SIZE];

  logic [COLOR_W-1:0]    color_r;
  logic                  last_r;
  logic [UW-1:0]         scan_addr_r, used_r;
  logic [COLOR_W-1:0]    rd_data_r;
  logic [IDX_W-1:0]      rd_idx_r, res_idx_r;
  logic                  rd_vld_r, res_new_r, res_full_r;
  logic [DIM_W-1:0]      col_r, row_r;
  logic                  overrun_r;
  logic [CFG_DATA_W-1:0] width_r, height_r;
  logic                  out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic             issue, more, mem_we, size_ok;
  logic [DIM_W-1:0] wm1, hm1;
  logic [CW-1:0]    wv, hv;

  assign more   = (scan_addr_r < used_r);
  assign issue  = cmd.scan && more;
  assign mem_we = cmd.resolve && !sts.hit && (used_r < UW'(PALETTE_SIZE));

  assign sts.hit       = rd_vld_r && (rd_data_r == color_r);
  assign sts.scan_done = !more;
  assign sts.out_free  = !out_tvalid_r || out_tready;

  // clamped size minus one: zero acts as one, oversize as MAX_DIMENSION
  assign wv = CW'(width_r);
  assign hv = CW'(height_r);
  always_comb begin
    if (wv == '0)                  wm1 = '0;
    else if (wv > CW'(MAX_DIMENSION)) wm1 = DIM_W'(MAX_DIMENSION - 1);
    else                           wm1 = DIM_W'(wv - CW'(1));
    if (hv == '0)                  hm1 = '0;
    else if (hv > CW'(MAX_DIMENSION)) hm1 = DIM_W'(MAX_DIMENSION - 1);
    else                           hm1 = DIM_W'(hv - CW'(1));
  end

  assign size_ok = last_r && !overrun_r && (row_r == hm1) && (col_r == wm1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[used_r[IDX_W-1:0]] <= color_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= mem[scan_addr_r[IDX_W-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      color_r <= in_tdata[COLOR_W-1:0];
      last_r  <= in_tlast;
    end
    if (issue) begin
      rd_idx_r <= scan_addr_r[IDX_W-1:0];
    end
    if (cmd.resolve) begin
      if (sts.hit) begin
        res_idx_r  <= rd_idx_r;
        res_new_r  <= 1'b0;
        res_full_r <= 1'b0;
      end else if (mem_we) begin
        res_idx_r  <= used_r[IDX_W-1:0];
        res_new_r  <= 1'b1;
        res_full_r <= 1'b0;
      end else begin
        res_idx_r  <= '0;
        res_new_r  <= 1'b0;
        res_full_r <= 1'b1;
      end
    end
    if (cmd.emit) begin
      out_tdata_r <= {{(OUT_TDATA_W - OUT_OK_BIT - 1){1'b0}}, size_ok,
                      POS_W'(col_r), POS_W'(row_r), res_full_r, res_new_r,
                      PAL_INDEX_W'(res_idx_r)};
    end
  end

  // control and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r  <= '0;
      used_r       <= '0;
      rd_vld_r     <= 1'b0;
      col_r        <= '0;
      row_r        <= '0;
      overrun_r    <= 1'b0;
      width_r      <= CFG_DATA_W'(1);
      height_r     <= CFG_DATA_W'(1);
      out_tvalid_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (cmd.load) begin
        scan_addr_r <= '0;
      end else if (issue) begin
        scan_addr_r <= scan_addr_r + UW'(1);
      end
      if (mem_we) begin
        used_r <= used_r + UW'(1);
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  width_r  <= cfg_data;
          REG_IMAGE_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.emit) begin
        out_tvalid_r <= 1'b1;
        if (last_r) begin
          used_r    <= '0;
          col_r     <= '0;
          row_r     <= '0;
          overrun_r <= 1'b0;
        end else if (col_r >= wm1) begin
          col_r <= '0;
          if (row_r >= DIM_W'(MAX_DIMENSION - 1)) begin
            overrun_r <= 1'b1;
          end else begin
            row_r <= row_r + DIM_W'(1);
          end
        end else begin
          col_r <= col_r + DIM_W'(1);
        end
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

[src/color_palette_indexer_top.sv]
`timescale 1ns / 1ps
// Color palette indexer: maps each RGB pixel of a raster stream to a
// palette index. Top level; depends on cpi_pkg, cpi_ctrl, cpi_datapath.
//
// Usage:
//   in_*  : one pixel per request, tdata = {blue, green, red} (red lowest),
//           tlast marks the final pixel of an image.
//   out_* : one result per pixel, in order (fields listed at the port).
//   cfg_* : size registers, index 0 = image_width, 1 = image_height.
//           cfg_ready is always high; write only while the block is idle.
//   Each pixel is compared against the palette one entry per clock, read
//   from the single-port palette memory. The search ends on the first match
//   or once every used entry has been read (a miss: new color or full
//   palette). The result is then loaded into the output register from the
//   FINISH state, and only after that is the next pixel taken in IDLE; a
//   new pixel is never accepted while one is still being searched.
//   After a tlast pixel the palette and raster position restart for the
//   next image; the size registers are kept.
//   Reset (rst_n low, synchronous) empties the palette, zeroes the raster
//   counters and sets both sizes to 1. No clearing pass is needed.
//   When out_tready is low the result is held in the output register; the
//   next pixel is still accepted and searched, and waits there until the
//   output register frees.
module color_palette_indexer_top
  import cpi_pkg::*;
#(
  parameter int PALETTE_SIZE  = PALETTE_SIZE_DEF,
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // pixel input
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  input  logic                   in_tlast,   // last_pixel
  // result output
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [9:0] palette_index, [10] is_new_color,
                                             // [11] palette_full, [23:12] pixel_row,
                                             // [35:24] pixel_col, [36] size_ok, [39:37] 0
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cpi_cmd_t cmd;
  cpi_sts_t sts;

  // size registers take a write in any cycle
  assign cfg_ready = 1'b1;

  cpi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cpi_datapath #(
    .PALETTE_SIZE  (PALETTE_SIZE),
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[src/cpi_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the color palette indexer, bound to the top.
// Depends on cpi_pkg and color_palette_indexer_top.
module cpi_port_checker
  import cpi_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result request dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("stalled result changed");

  a_new_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[OUT_NEW_BIT] && out_tdata[OUT_FULL_BIT]))
    else $error("result both new color and palette full");

  a_full_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_FULL_BIT] |-> out_tdata[PAL_INDEX_W-1:0] == '0)
    else $error("palette full result with nonzero index");

endmodule

bind color_palette_indexer_top cpi_port_checker u_cpi_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[sim/cpi_checker.sv]
`timescale 1ns / 1ps
// Result checker for the color palette indexer: watches the pixel, result and
// size-register channels, predicts each result and compares it.
// Depends on cpi_pkg.
module cpi_checker
  import cpi_pkg::*;
#(
  parameter int PALETTE_SIZE  = PALETTE_SIZE_DEF,
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     outstanding
);

  localparam int MAX_REPORTS = 40;

  // same layout as out_tdata[36:0]
  typedef struct packed {
    logic                   size_ok;
    logic [POS_W-1:0]       col;
    logic [POS_W-1:0]       row;
    logic                   full;
    logic                   is_new;
    logic [PAL_INDEX_W-1:0] index;
  } pix_result_t;

  logic [COLOR_W-1:0]    palette [PALETTE_SIZE];
  int unsigned           used;
  int unsigned           next_col;
  int unsigned           next_row;
  bit                    overrun;
  logic [CFG_DATA_W-1:0] width_q;
  logic [CFG_DATA_W-1:0] height_q;
  pix_result_t           pending_q [$];
  int                    err_cnt = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic int unsigned eff_dim(input logic [CFG_DATA_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIMENSION) return MAX_DIMENSION;
    return v;
  endfunction

  // Palette lookup/append plus raster position for one pixel.
  task automatic index_pixel(input logic [COLOR_W-1:0] color, input logic last,
                             output pix_result_t r);
    int unsigned w;
    int unsigned h;
    bit          found;
    w     = eff_dim(width_q);
    h     = eff_dim(height_q);
    r     = '0;
    found = 1'b0;
    for (int i = 0; i < used; i++) begin
      if (palette[i] == color) begin
        r.index = PAL_INDEX_W'(i);
        found   = 1'b1;
        break;
      end
    end
    if (!found) begin
      if (used < PALETTE_SIZE) begin
        palette[used] = color;
        r.index       = PAL_INDEX_W'(used);
        r.is_new      = 1'b1;
        used++;
      end else begin
        r.full = 1'b1;
      end
    end
    r.row = POS_W'(next_row);
    r.col = POS_W'(next_col);
    if (last)
      r.size_ok = !overrun && next_row == h - 1 && next_col == w - 1;
    if (next_col >= w - 1) begin
      next_col = 0;
      if (next_row >= MAX_DIMENSION - 1) overrun = 1'b1;
      else next_row++;
    end else begin
      next_col++;
    end
    if (last) begin
      used     = 0;
      next_col = 0;
      next_row = 0;
      overrun  = 1'b0;
    end
  endtask

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    pix_result_t got;
    pix_result_t want;
    if (!rst_n) begin
      used     = 0;
      next_col = 0;
      next_row = 0;
      overrun  = 1'b0;
      width_q  = 1;
      height_q = 1;
      pending_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_q  = cfg_data;
          REG_IMAGE_HEIGHT: height_q = cfg_data;
        endcase
      end
      // results first: a result never belongs to a pixel taken at the same edge
      if (out_tvalid && out_tready) begin
        got = out_tdata[OUT_OK_BIT:0];
        if (pending_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: result expected none, actual %h", $time, out_tdata);
        end else begin
          want = pending_q.pop_front();
          check_field("palette_index", want.index, got.index);
          check_field("is_new_color", want.is_new, got.is_new);
          check_field("palette_full", want.full, got.full);
          check_field("pixel_row", want.row, got.row);
          check_field("pixel_col", want.col, got.col);
          check_field("size_ok", want.size_ok, got.size_ok);
        end
      end
      if (in_tvalid && in_tready) begin
        index_pixel(in_tdata, in_tlast, want);
        pending_q.push_back(want);
      end
    end
    mismatches  <= err_cnt;
    outstanding <= pending_q.size();
  end

endmodule

[sim/color_palette_indexer_top_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the color palette indexer: drives pixel and size-register
// requests, stalls the result side at random and prints the verdict.
// Depends on cpi_pkg, color_palette_indexer_top and cpi_checker.
module color_palette_indexer_top_tb;
  import cpi_pkg::*;

  localparam int RESET_CYCLES  = 9;
  localparam int RANDOM_PIXELS = 200;
  // the palette capacity image alone runs long; leave plenty of room
  localparam int CYCLE_LIMIT   = 4_000_000;
  // slowest pixel searches a full palette
  localparam int SETTLE_CYCLES = 1100;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [7:0] red, [15:8] green, [23:16] blue
  logic                   in_tlast   = 1'b0; // last_pixel
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [9:0] index, [10] new, [11] full,
                                             // [23:12] row, [35:24] col, [36] size_ok
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  int          mismatches;
  int          outstanding;
  int          cycles      = 0;
  int          pixels_sent = 0;
  bit          calm        = 1'b0;  // no idling on either side while set
  int unsigned cur_w       = 1;     // effective sizes, for shaping images
  int unsigned cur_h       = 1;

  color_palette_indexer_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  cpi_checker palette_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // result side: drops ready in ~6% of cycles unless calm
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 6);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // tdata packs red lowest
  function automatic logic [IN_TDATA_W-1:0] rgb(input logic [7:0] r, g, b);
    return {b, g, r};
  endfunction

  // mostly small sizes, now and then a zero (acts as 1)
  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    if ($urandom_range(99) < 4) return '0;
    return CFG_DATA_W'($urandom_range(8, 1));
  endfunction

  // One pixel request; returns at the edge that accepted it with valid still up,
  // so back-to-back pixels go out without a bubble.
  task automatic send_pixel(input logic [IN_TDATA_W-1:0] color, input logic last);
    if (!calm && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= color;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels_sent++;
  endtask

  // Sender pauses until every pixel sent so far has its result.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Size writes only ever happen with the block idle.
  task automatic write_size(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] value);
    int unsigned eff;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    eff = (value == 0) ? 1 : (value > MAX_DIMENSION_DEF) ? MAX_DIMENSION_DEF : value;
    if (idx == REG_IMAGE_WIDTH) cur_w = eff;
    else cur_h = eff;
  endtask

  // Pixels drawn from a small random color set; tlast on the final one if closed.
  task automatic paint_image(input int n_pix, input int n_colors, input bit close);
    logic [IN_TDATA_W-1:0] pool [$];
    repeat (n_colors) pool.push_back(IN_TDATA_W'($urandom()));
    for (int p = 0; p < n_pix; p++)
      send_pixel(pool[$urandom_range(n_colors - 1)], close && p == n_pix - 1);
  endtask

  // Image with n_new distinct colors plus a few repeats. k * odd is a bijection
  // mod 2^24, so every fresh color really is new; past 1024 the palette is full.
  task automatic fill_palette(input int n_pix, input int n_new);
    logic [IN_TDATA_W-1:0] salt;
    logic [IN_TDATA_W-1:0] color;
    int                    made;
    bit                    fresh;
    salt = IN_TDATA_W'($urandom());
    made = 0;
    for (int p = 0; p < n_pix; p++) begin
      fresh = made < n_new &&
              (made == 0 || n_new - made >= n_pix - p || $urandom_range(99) >= 3);
      if (fresh) begin
        color = salt ^ IN_TDATA_W'(made * 32'h009E_3779);
        made++;
      end else begin
        color = salt ^ IN_TDATA_W'($urandom_range(made - 1) * 32'h009E_3779);
      end
      send_pixel(color, p == n_pix - 1);
    end
  endtask

  initial begin
    int base;
    int sel;
    int n_pix;
    int n_colors;
    bit close;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // reset sizes 1x1: a lone last pixel sits on the corner
    send_pixel(rgb(8'h00, 8'h00, 8'h00), 1'b1);

    write_size(REG_IMAGE_WIDTH, 3);
    write_size(REG_IMAGE_HEIGHT, 2);
    // exact 3x2 image: extreme channel values, repeats of earlier colors
    send_pixel(rgb(8'hFF, 8'hFF, 8'hFF), 1'b0);
    send_pixel(rgb(8'h00, 8'h00, 8'h00), 1'b0);
    send_pixel(rgb(8'hFF, 8'hFF, 8'hFF), 1'b0);
    send_pixel(rgb(8'hFF, 8'h00, 8'h00), 1'b0);
    send_pixel(rgb(8'h00, 8'hFF, 8'h00), 1'b0);
    send_pixel(rgb(8'h00, 8'h00, 8'hFF), 1'b1);
    // last arrives early, then late (rows run past the height)
    paint_image(4, 3, 1'b1);
    paint_image(8, 2, 1'b1);
    // width changes in the middle of an image
    paint_image(2, 2, 1'b0);
    write_size(REG_IMAGE_WIDTH, 2);
    paint_image(2, 2, 1'b1);
    // zero sizes behave as 1
    write_size(REG_IMAGE_WIDTH, 0);
    write_size(REG_IMAGE_HEIGHT, 0);
    paint_image(1, 1, 1'b1);
    paint_image(1, 1, 1'b1);

    // oversize width clamps to 4096: a short row stays on row 0
    write_size(REG_IMAGE_WIDTH, 8191);
    write_size(REG_IMAGE_HEIGHT, 1);
    paint_image(40, 3, 1'b1);
    // palette runs out of entries near the end of a 33x32 image
    write_size(REG_IMAGE_WIDTH, 33);
    write_size(REG_IMAGE_HEIGHT, 32);
    fill_palette(33 * 32, 1034);

    // --- random images ---
    // mostly well-formed images; some end early or late, some stay open
    // and run on into the next one
    base = pixels_sent;
    while (pixels_sent < base + RANDOM_PIXELS) begin
      calm <= (pixels_sent - base >= 40) && (pixels_sent - base < 120);
      if ($urandom_range(99) < 30) begin
        write_size(REG_IMAGE_WIDTH, pick_dim());
        if ($urandom_range(1) == 1) write_size(REG_IMAGE_HEIGHT, pick_dim());
      end
      n_colors = ($urandom_range(9) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
      sel = $urandom_range(99);
      if (sel < 70) begin
        n_pix = cur_w * cur_h;
        close = 1'b1;
      end else if (sel < 90) begin
        n_pix = $urandom_range(cur_w * cur_h + 3, 1);
        close = 1'b1;
      end else begin
        n_pix = $urandom_range(cur_w * cur_h, 1);
        close = 1'b0;
      end
      paint_image(n_pix, n_colors, close);
    end
    calm <= 1'b0;

    // drain, then give a straggler time to show up
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[color_palette_indexer_top.f]
src/cpi_pkg.sv
src/cpi_ctrl.sv
src/cpi_datapath.sv
src/color_palette_indexer_top.sv
src/cpi_checker.sv
sim/cpi_checker.sv
sim/color_palette_indexer_top_tb.sv
